[rtl/assert_macros.svh]
// Assertion helpers used by knn_topk_selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define KTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

`define KTS_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`else

`define KTS_ASSERT(lbl, clk, rstn, prop)

`define KTS_ASSERT_MSG(lbl, clk, rstn, prop, msg)

`endif

`endif

[rtl/kts_pkg.sv]
package kts_pkg;

  localparam int unsigned DIST_W = 40;
  localparam int unsigned ID_W   = 24;
  localparam int unsigned SQ_W   = 32;

  localparam logic [7:0] DIMS_RST = 8'd128;
  localparam logic [6:0] K_RST    = 7'd10;

  // configuration register indexes
  localparam logic [0:0] CFG_DIMS = 1'b0;
  localparam logic [0:0] CFG_K    = 1'b1;

  // result kinds
  localparam logic RK_VERDICT = 1'b0;
  localparam logic RK_SLOT    = 1'b1;

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_CAND  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   id;
  } hent_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } acc_ctrl_t;

endpackage

[rtl/knn_topk_selector.sv]
// Channel  Dir  tdata / tuser / tlast
// s_axis   in   tdata: coord_index, coord_value, point_id; tuser: req_type; tlast: last_coord
// m_axis   out  tdata: out_id, sq_distance, accepted, radius, heap_count; tuser: result_kind
// cfg      in   cfg_we_i, cfg_index_i (0 dims_in_use, 1 k_in_use), cfg_data_i
//
// Query writes and clears are handled without leaving the idle state. Candidate
// coordinate: query RAM read, multiply, accumulate through the square/accumulate unit.
// Last coordinate adds a judge step, per heap level walked by the sift one heap RAM
// read and one compare/write, then an output step. Slot read: RAM read, capture, output.
// Reset is asynchronous, active low; heap empty, dims_in_use 128, k_in_use 10.
// A pending result waits in the output register; the block stalls only in its
// output step when that register is still full.
`include "assert_macros.svh"

module knn_topk_selector #(
  parameter int unsigned MAX_DIMS      = 128,
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // coord_index[6:0], coord_value[22:7], point_id[46:23]
  input  logic [1:0]    s_axis_tuser,   // req_type[1:0]
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // out_id[23:0], sq_distance[63:24], accepted[64],
                                        // radius[104:65], heap_count[111:105]
  output logic [0:0]    m_axis_tuser,   // result_kind[0]
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);
  import kts_pkg::*;

  localparam int unsigned QW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRD,
    S_MUL,
    S_ACC,
    S_JUDGE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_SLOT_RD,
    S_SLOT_GET,
    S_OUT
  } state_e;

  state_e             state_q;
  logic               out_valid_q;
  logic [CW-1:0]      heap_size_q;
  logic [7:0]         dims_q;
  logic [6:0]         k_q;
  logic               grow_q;

  logic [6:0]         in_idx_q;
  logic [15:0]        in_val_q;
  logic [ID_W-1:0]    in_pid_q;
  logic               in_last_q;
  logic [15:0]        q_rd_q;
  logic [DIST_W-1:0]  cand_dist_q;
  logic [DIST_W-1:0]  root_q;
  logic [AW-1:0]      pos_q;
  logic               res_kind_q;
  logic               res_acc_q;
  logic [ID_W-1:0]    res_id_q;
  logic [DIST_W-1:0]  res_dist_q;
  logic [111:0]       out_data_q;
  logic               out_kind_q;

  logic [15:0]        qmem [MAX_DIMS];

  logic               in_fire;
  req_e               in_req;
  logic [31:0]        s_idx32;
  logic [31:0]        idx32;
  logic [31:0]        hs32;
  logic [31:0]        k32;
  logic [31:0]        keff32;
  logic               have_room;
  logic               closer;
  logic               coord_used;
  logic [AW-1:0]      parent;
  logic [AW+1:0]      lc;
  logic [AW+1:0]      rc;
  logic               l_in;
  logic               r_in;
  logic               pick_r;
  hent_t              big;
  logic [AW-1:0]      big_idx;
  hent_t              new_ent;
  logic               sift_done;
  logic               out_load;
  logic [DIST_W-1:0]  radius;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  hent_t              ram_wdata;
  logic [AW-1:0]      ram_ra;
  logic [AW-1:0]      ram_rb;
  hent_t              rd_a;
  hent_t              rd_b;

  acc_ctrl_t          acc_ctrl;
  logic [DIST_W-1:0]  acc_sum;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_req  = req_e'(s_axis_tuser);
  assign s_idx32 = 32'(s_axis_tdata[6:0]);
  assign idx32   = 32'(in_idx_q);
  assign hs32    = 32'(heap_size_q);
  assign k32     = 32'(k_q);

  always_comb begin
    if (k32 == 32'd0) begin
      keff32 = 32'd1;
    end else if (k32 > MAX_NEIGHBORS) begin
      keff32 = MAX_NEIGHBORS;
    end else begin
      keff32 = k32;
    end
  end

  assign have_room  = hs32 < keff32;
  assign closer     = acc_sum < root_q;
  assign coord_used = (idx32 < 32'(dims_q)) && (idx32 < MAX_DIMS);

  // heap neighbors of the current hole
  assign parent  = (pos_q - AW'(1)) >> 1;
  assign lc      = {1'b0, pos_q, 1'b1};
  assign rc      = lc + {{(AW + 1){1'b0}}, 1'b1};
  assign l_in    = 32'(lc) < hs32;
  assign r_in    = 32'(rc) < hs32;
  assign pick_r  = r_in && (rd_b.sq_dist > rd_a.sq_dist);  // left wins ties
  assign big     = pick_r ? rd_b : rd_a;
  assign big_idx = pick_r ? rc[AW-1:0] : lc[AW-1:0];
  assign new_ent = '{sq_dist: cand_dist_q, id: in_pid_q};

  // hole-based sift: the new entry is written once, at its final slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = new_ent;
    ram_ra    = lc[AW-1:0];
    ram_rb    = rc[AW-1:0];
    sift_done = 1'b0;
    case (state_q)
      S_UP_RD: begin
        ram_ra = parent;
        if (pos_q == '0) begin
          ram_we    = 1'b1;
          sift_done = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (rd_a.sq_dist >= cand_dist_q) begin
          sift_done = 1'b1;
        end else begin
          ram_wdata = rd_a;
        end
      end
      S_DN_RD: begin
        if (!l_in) begin
          ram_we    = 1'b1;
          sift_done = 1'b1;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (big.sq_dist <= cand_dist_q) begin
          sift_done = 1'b1;
        end else begin
          ram_wdata = big;
        end
      end
      S_SLOT_RD: begin
        ram_ra = idx32[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    acc_ctrl.clr    = (in_fire && (in_req == REQ_CLEAR)) || (state_q == S_JUDGE);
    acc_ctrl.mul_en = state_q == S_MUL;
    acc_ctrl.acc_en = (state_q == S_ACC) && coord_used;
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign radius   = (heap_size_q == '0) ? '1 : root_q;

  kts_dist_acc u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .query_i (q_rd_q),
    .coord_i (in_val_q),
    .sum_o   (acc_sum)
  );

  kts_heap_ram #(
    .Depth (MAX_NEIGHBORS)
  ) u_heap (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_ra),
    .raddr_b_i (ram_rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // query store
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_req == REQ_QUERY) && (s_idx32 < MAX_DIMS)) begin
      qmem[s_idx32[QW-1:0]] <= s_axis_tdata[22:7];
    end
    q_rd_q <= qmem[idx32[QW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      heap_size_q <= '0;
      dims_q      <= DIMS_RST;
      k_q         <= K_RST;
      grow_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DIMS: dims_q <= cfg_data_i;
          CFG_K:    k_q    <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (in_req)
              REQ_CAND:  state_q     <= S_QRD;
              REQ_READ:  state_q     <= S_SLOT_RD;
              REQ_CLEAR: heap_size_q <= '0;
              default: begin
              end
            endcase
          end
        end
        S_QRD:   state_q <= S_MUL;
        S_MUL:   state_q <= S_ACC;
        S_ACC:   state_q <= in_last_q ? S_JUDGE : S_IDLE;
        S_JUDGE: begin
          if (have_room) begin
            grow_q  <= 1'b1;
            state_q <= S_UP_RD;
          end else if ((heap_size_q != '0) && closer) begin
            grow_q  <= 1'b0;
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP: begin
          if (sift_done) begin
            state_q <= S_OUT;
            if (grow_q) begin
              heap_size_q <= heap_size_q + CW'(1);
            end
          end else begin
            case (state_q)
              S_UP_RD:  state_q <= S_UP_CMP;
              S_UP_CMP: state_q <= S_UP_RD;
              S_DN_RD:  state_q <= S_DN_CMP;
              default:  state_q <= S_DN_RD;
            endcase
          end
        end
        S_SLOT_RD:  state_q <= S_SLOT_GET;
        S_SLOT_GET: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_idx_q  <= s_axis_tdata[6:0];
      in_val_q  <= s_axis_tdata[22:7];
      in_pid_q  <= s_axis_tdata[46:23];
      in_last_q <= s_axis_tlast;
    end
    if (ram_we && (ram_waddr == '0)) begin
      root_q <= ram_wdata.sq_dist;
    end
    case (state_q)
      S_JUDGE: begin
        cand_dist_q <= acc_sum;
        res_kind_q  <= RK_VERDICT;
        res_id_q    <= in_pid_q;
        res_dist_q  <= acc_sum;
        res_acc_q   <= have_room || ((heap_size_q != '0) && closer);
        pos_q       <= have_room ? hs32[AW-1:0] : '0;
      end
      S_UP_CMP: begin
        if (!sift_done) begin
          pos_q <= parent;
        end
      end
      S_DN_CMP: begin
        if (!sift_done) begin
          pos_q <= big_idx;
        end
      end
      S_SLOT_GET: begin
        res_kind_q <= RK_SLOT;
        res_acc_q  <= 1'b0;
        if ((idx32 < hs32) && (idx32 < MAX_NEIGHBORS)) begin
          res_id_q   <= rd_a.id;
          res_dist_q <= rd_a.sq_dist;
        end else begin
          res_id_q   <= '0;
          res_dist_q <= '0;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= {hs32[6:0], radius, res_acc_q, res_dist_q, res_id_q};
      out_kind_q <= res_kind_q;
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  `KTS_ASSERT(a_size_bound, clk_i, rst_ni, hs32 <= MAX_NEIGHBORS)
  `KTS_ASSERT_MSG(a_size_step, clk_i, rst_ni, (heap_size_q != $past(heap_size_q)) |-> ((heap_size_q == '0) || (hs32 == 32'($past(heap_size_q)) + 32'd1)), "heap size jumped")
  `KTS_ASSERT_MSG(a_down_in_heap, clk_i, rst_ni, (state_q == S_DN_CMP) |-> (32'(pos_q) < hs32), "sift-down hole outside heap")
  `KTS_ASSERT(a_up_nonroot, clk_i, rst_ni, (state_q == S_UP_CMP) |-> (pos_q != '0))

endmodule

[rtl/kts_dist_acc.sv]
module kts_dist_acc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kts_pkg::acc_ctrl_t               ctrl_i,
  input  logic signed [15:0]               query_i,
  input  logic signed [15:0]               coord_i,
  output logic [kts_pkg::DIST_W-1:0]       sum_o
);
  import kts_pkg::*;

  logic signed [16:0]   diff;
  logic signed [33:0]   prod;
  logic [SQ_W-1:0]      sq_q;
  logic [DIST_W:0]      sum_w;
  logic [DIST_W-1:0]    acc_q;

  assign diff  = {query_i[15], query_i} - {coord_i[15], coord_i};
  assign prod  = diff * diff;
  assign sum_w = {1'b0, acc_q} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_q};

  // square is never negative and stays below 2^32
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      sq_q <= prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= sum_w[DIST_W] ? '1 : sum_w[DIST_W-1:0];
    end
  end

  assign sum_o = acc_q;

endmodule

[rtl/kts_heap_ram.sv]
module kts_heap_ram #(
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [Aw-1:0]       waddr_i,
  input  kts_pkg::hent_t      wdata_i,
  input  logic [Aw-1:0]       raddr_a_i,
  input  logic [Aw-1:0]       raddr_b_i,
  output kts_pkg::hent_t      rdata_a_o,
  output kts_pkg::hent_t      rdata_b_o
);
  import kts_pkg::*;

  hent_t mem [Depth];
  hent_t rd_a_q;
  hent_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem[raddr_a_i];
    rd_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule
